// ===== sv/chsc_pkg.sv =====
// Package for the census Hamming stereo cost block.
// Holds shared widths, register indexes and the front-to-back job record.
package chsc_pkg;

   localparam int unsigned MaxWidthDefault = 1024;
   localparam int unsigned MaxDispDefault  = 64;
   localparam int unsigned CsrIndexWidth   = 2;
   localparam int unsigned CsrDataWidth    = 11;
   localparam int unsigned CensusBits      = 25;
   localparam int unsigned CountWidth      = 21;
   localparam logic [7:0]  OutOfRangeCost  = 8'd128;

   typedef enum logic [CsrIndexWidth-1:0] {
      REG_FRAME_WIDTH     = 2'd0,
      REG_FRAME_HEIGHT    = 2'd1,
      REG_MIN_DISPARITY   = 2'd2,
      REG_DISPARITY_COUNT = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      BACK_IDLE  = 2'd0,
      BACK_READ  = 2'd1,
      BACK_EMIT  = 2'd2
   } back_state_type;

   // One census job handed from the front to the back.
   typedef struct packed {
      logic [CensusBits-1:0] left_census;
      logic [CensusBits-1:0] right_census;
      logic [10:0]           out_column;
      logic                  frame_end;
   } job_type;

   // Population count of a census difference.
   function automatic logic [4:0] ones25(input logic [CensusBits-1:0] v);
      logic [4:0] n;
      n = '0;
      for (int i = 0; i < CensusBits; i++) begin
         n = n + {4'd0, v[i]};
      end
      return n;
   endfunction

   // Census of a 5x5 window packed with entry 0 in the low byte; entry 0 maps to the top census bit.
   function automatic logic [CensusBits-1:0] census_of(input logic [199:0] w);
      logic [CensusBits-1:0] v;
      logic [7:0] c;
      c = w[8*12 +: 8];
      for (int i = 0; i < 25; i++) begin
         v[24-i] = (w[8*i +: 8] < c);
      end
      return v;
   endfunction

endpackage

// ===== sv/chsc_stream_if.sv =====
// Valid/ready channel interface with source and sink modports.
// Payload type is a parameter; no package dependency.
interface chsc_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== sv/chsc_front.sv =====
// Front part: line stores, 5x5 windows, census and frame counters.
// Depends on chsc_pkg; produces census jobs for the back part.
module chsc_front #(
   parameter int unsigned MAX_WIDTH = chsc_pkg::MaxWidthDefault
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_kind,
   input  logic [7:0]              req_left_pixel,
   input  logic [7:0]              req_right_pixel,
   input  logic [10:0]             cfg_width,
   input  logic [10:0]             cfg_height,
   output logic                    job_valid,
   input  logic                    job_ready,
   output chsc_pkg::job_type       job_data
);
   import chsc_pkg::*;

   localparam int unsigned ColBits = $clog2(MAX_WIDTH);

   logic [199:0] left_win_ff, left_win_in, right_win_ff, right_win_in;
   logic [10:0]  row_ff, row_in, col_ff, col_in;
   logic [CountWidth-1:0] items_ff, items_in;
   logic [CountWidth-1:0] orow_ff, orow_in, ocol_ff, ocol_in;

   // Three-phase handling: accept and read the stores, shift the windows, form the census.
   logic         busy_ff, busy_in;
   logic         emit_ff, emit_in;
   logic         form_ff;
   logic         shift_ff, shift_in;
   logic [7:0]   lp_ff, rp_ff;
   logic [1:0]   slot_row_ff;
   logic [7:0]   left_bank_q [4];
   logic [7:0]   right_bank_q [4];
   logic [31:0]  lcol, rcol;
   logic [10:0]  w_eff, h_eff;
   logic [CountWidth-1:0] total, lag, q0;
   logic [10:0]  r0, c0;
   logic         border;
   logic         last_ff, last_in;
   logic [10:0]  jobcol_in;
   job_type      job_ff;
   logic         job_valid_ff, job_valid_in;
   logic         accept;

   always_comb begin
      w_eff = (cfg_width < 11'd6) ? 11'd6 :
              (32'(cfg_width) > MAX_WIDTH) ? 11'(MAX_WIDTH) : cfg_width;
      h_eff = (cfg_height < 11'd6) ? 11'd6 :
              (cfg_height > 11'd1024) ? 11'd1024 : cfg_height;
      total = CountWidth'(w_eff) * CountWidth'(h_eff);
      lag = CountWidth'({w_eff, 1'b0}) + CountWidth'(2);
   end

   assign req_ready = !busy_ff && !form_ff && !job_valid_ff;
   assign accept = req_valid && req_ready;

   // Normalize counters for the incoming request.
   logic stale;
   always_comb begin
      stale = items_ff >= total + lag;
      q0 = stale ? '0 : items_ff;
      r0 = stale ? '0 : row_ff;
      c0 = stale ? '0 : col_ff;
      if (c0 >= w_eff) begin
         c0 = '0;
         r0 = r0 + 11'd1;
      end
   end

   logic take_pixel;
   assign take_pixel = q0 < total;

   // Line stores: one bank per buffered row, each read and written at the request column.
   logic [ColBits-1:0] rd_col;
   assign rd_col = c0[ColBits-1:0];

   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [7:0] left_mem [MAX_WIDTH];
      logic [7:0] right_mem [MAX_WIDTH];
      logic [7:0] left_rd_ff, right_rd_ff;

      always_ff @(posedge clock) begin
         if (accept && take_pixel && !req_kind && r0[1:0] == 2'(b)) begin
            left_mem[rd_col] <= req_left_pixel;
            right_mem[rd_col] <= req_right_pixel;
         end
         if (accept) begin
            left_rd_ff <= left_mem[rd_col];
            right_rd_ff <= right_mem[rd_col];
         end
      end

      assign left_bank_q[b] = left_rd_ff;
      assign right_bank_q[b] = right_rd_ff;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         slot_row_ff <= r0[1:0];
         lp_ff <= req_left_pixel;
         rp_ff <= req_right_pixel;
      end
   end

   // The oldest buffered row sits in the bank of the request row.
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         lcol[8*(3-r) +: 8] = left_bank_q[2'(slot_row_ff + 2'(r))];
         rcol[8*(3-r) +: 8] = right_bank_q[2'(slot_row_ff + 2'(r))];
      end
   end

   // Counter and control update.
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      items_in = items_ff;
      busy_in = busy_ff;
      shift_in = 1'b0;
      emit_in = 1'b0;
      last_in = last_ff;
      if (accept && !(take_pixel && req_kind)) begin
         row_in = r0;
         col_in = c0;
         if (take_pixel) begin
            shift_in = 1'b1;
            col_in = c0 + 11'd1;
            if (col_in >= w_eff) begin
               col_in = '0;
               row_in = r0 + 11'd1;
            end
         end
         items_in = q0 + CountWidth'(1);
         busy_in = 1'b1;
         if (q0 >= lag) begin
            emit_in = 1'b1;
            last_in = (q0 - lag) == total - CountWidth'(1);
            if (last_in) begin
               row_in = '0;
               col_in = '0;
               items_in = '0;
            end
         end
      end else if (busy_ff) begin
         busy_in = 1'b0;
      end
   end

   // Windows shift one column when the store data is ready.
   always_comb begin
      left_win_in = left_win_ff;
      right_win_in = right_win_ff;
      if (shift_ff) begin
         for (int r = 0; r < 5; r++) begin
            for (int c = 0; c < 4; c++) begin
               left_win_in[8*(24-(r*5+c)) +: 8] = left_win_ff[8*(24-(r*5+c+1)) +: 8];
               right_win_in[8*(24-(r*5+c)) +: 8] = right_win_ff[8*(24-(r*5+c+1)) +: 8];
            end
         end
         for (int r = 0; r < 4; r++) begin
            left_win_in[8*(24-(r*5+4)) +: 8] = lcol[8*(3-r) +: 8];
            right_win_in[8*(24-(r*5+4)) +: 8] = rcol[8*(3-r) +: 8];
         end
         left_win_in[7:0] = lp_ff;
         right_win_in[7:0] = rp_ff;
      end
   end

   // Output position counters advance per emitted pixel and restart on the first one.
   always_comb begin
      orow_in = orow_ff;
      ocol_in = ocol_ff;
      if (form_ff) begin
         if (ocol_ff + 21'd1 >= CountWidth'(w_eff)) begin
            ocol_in = '0;
            orow_in = orow_ff + 21'd1;
         end else begin
            ocol_in = ocol_ff + 21'd1;
         end
      end
      if (emit_in && q0 == lag) begin
         orow_in = '0;
         ocol_in = '0;
      end
   end

   always_comb begin
      border = (orow_ff < 21'd2) || (orow_ff >= CountWidth'(h_eff) - 21'd2) ||
               (ocol_ff < 21'd2) || (ocol_ff >= CountWidth'(w_eff) - 21'd2);
      jobcol_in = ocol_ff[10:0];
      job_valid_in = (job_valid_ff && !job_ready) || form_ff;
   end

   // Window byte order is reversed: window entry i is at byte 24-i.
   function automatic logic [199:0] flip(input logic [199:0] w);
      logic [199:0] o;
      for (int i = 0; i < 25; i++) begin
         o[8*i +: 8] = w[8*(24-i) +: 8];
      end
      return o;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
         items_ff <= '0;
         busy_ff <= 1'b0;
         shift_ff <= 1'b0;
         emit_ff <= 1'b0;
         form_ff <= 1'b0;
         last_ff <= 1'b0;
         job_valid_ff <= 1'b0;
         left_win_ff <= '0;
         right_win_ff <= '0;
         orow_ff <= '0;
         ocol_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
         items_ff <= items_in;
         busy_ff <= busy_in;
         shift_ff <= shift_in;
         emit_ff <= emit_in;
         form_ff <= emit_ff;
         last_ff <= last_in;
         left_win_ff <= left_win_in;
         right_win_ff <= right_win_in;
         orow_ff <= orow_in;
         ocol_ff <= ocol_in;
         job_valid_ff <= job_valid_in;
         // Census is formed the cycle after the window shift.
         if (form_ff) begin
            job_ff.left_census <= border ? '0 : census_of(flip(left_win_ff));
            job_ff.right_census <= border ? '0 : census_of(flip(right_win_ff));
            job_ff.out_column <= jobcol_in;
            job_ff.frame_end <= last_ff;
         end
      end
   end

   assign job_valid = job_valid_ff;
   assign job_data = job_ff;

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !req_ready) else $error("request accepted while busy");
   a_job_hold: assert property (@(posedge clock) disable iff (reset)
      job_valid && !job_ready |=> job_valid) else $error("job dropped");
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      shift_ff |-> $past(accept)) else $error("window shift without request");
`endif
endmodule

// ===== sv/chsc_back.sv =====
// Back part: right census row memory and per-disparity Hamming costs.
// Depends on chsc_pkg; consumes census jobs and drives the result channel.
module chsc_back #(
   parameter int unsigned MAX_WIDTH = chsc_pkg::MaxWidthDefault,
   parameter int unsigned MAX_DISP  = chsc_pkg::MaxDispDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_ready,
   input  chsc_pkg::job_type job_data,
   input  logic [5:0]        cfg_min_disp,
   input  logic [6:0]        cfg_disp_count,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_match_cost,
   output logic [5:0]        rsp_disparity_offset,
   output logic              rsp_last_of_pixel,
   output logic              rsp_last_of_frame
);
   import chsc_pkg::*;

   localparam int unsigned ColBits = $clog2(MAX_WIDTH);
   localparam int unsigned KBits = $clog2(MAX_DISP + 1);

   logic [CensusBits-1:0] census_row [MAX_WIDTH];

   back_state_type state_ff, state_in;
   job_type job_ff;
   logic [KBits-1:0] k_ff, k_in, cnt;
   logic [11:0] d;
   logic [CensusBits-1:0] rd_ff;
   logic out_range_ff;
   logic [5:0] koff_ff;
   logic lastp_ff, lastf_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic [7:0] cost_ff;
   logic issue;

   assign cnt = (cfg_disp_count == 7'd0) ? KBits'(1) :
                (32'(cfg_disp_count) > MAX_DISP) ? KBits'(MAX_DISP) :
                KBits'(cfg_disp_count);
   assign d = 12'(cfg_min_disp) + 12'(k_ff);
   assign job_ready = (state_ff == BACK_IDLE);

   // Read the stored right census for one disparity at a time; a read waits while an unaccepted result is held.
   assign issue = (state_ff == BACK_READ) && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (job_valid && job_ready) begin
         census_row[job_data.out_column[ColBits-1:0]] <= job_data.right_census;
      end
      if (issue) begin
         rd_ff <= census_row[ColBits'(job_ff.out_column - 11'(d))];
      end
   end

   always_comb begin
      state_in = state_ff;
      k_in = k_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         BACK_IDLE: begin
            if (job_valid) begin
               state_in = BACK_READ;
               k_in = '0;
            end
         end
         BACK_READ: begin
            if (issue) begin
               state_in = BACK_EMIT;
            end
         end
         BACK_EMIT: begin
            rsp_valid_in = 1'b1;
            if (k_ff + KBits'(1) == cnt) begin
               state_in = BACK_IDLE;
            end else begin
               k_in = k_ff + KBits'(1);
               state_in = BACK_READ;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_IDLE;
         k_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_ff <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_valid && job_ready) begin
         job_ff <= job_data;
      end
      if (issue) begin
         out_range_ff <= d > 12'(job_ff.out_column);
         koff_ff <= 6'(k_ff);
         lastp_ff <= (k_ff + KBits'(1) == cnt);
         lastf_ff <= (k_ff + KBits'(1) == cnt) && job_ff.frame_end;
      end
      if (state_ff == BACK_EMIT) begin
         cost_ff <= out_range_ff ? OutOfRangeCost :
                    {3'd0, ones25(job_ff.left_census ^ rd_ff)};
         rsp_disparity_offset <= koff_ff;
         rsp_last_of_pixel <= lastp_ff;
         rsp_last_of_frame <= lastf_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_match_cost = cost_ff;

`ifndef SYNTHESIS
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
   a_issue: assert property (@(posedge clock) disable iff (reset)
      state_ff == BACK_EMIT |-> $past(issue)) else $error("emit without read");
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_of_frame |-> rsp_last_of_pixel)
      else $error("frame end off pixel end");
`endif
endmodule

// ===== sv/census_hamming_stereo_cost.sv =====
// Top level of the census Hamming stereo cost block.
// Depends on chsc_pkg, chsc_stream_if, chsc_front and chsc_back.
//
// Each accepted request passes through the front as store read, window shift and
// census; the back then produces one result per disparity, each from a census row
// read followed by the cost. The back does not overlap one read with the previous
// cost and takes a new pixel only after the cost of the last disparity of the one
// before. Results lag the input by two rows plus two pixels; padding requests flush
// the frame.
module census_hamming_stereo_cost #(
   parameter int unsigned MAX_WIDTH = chsc_pkg::MaxWidthDefault,
   parameter int unsigned MAX_DISP  = chsc_pkg::MaxDispDefault
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_kind,
   input  logic [7:0] req_left_pixel,
   input  logic [7:0] req_right_pixel,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [7:0] rsp_match_cost,
   output logic [5:0] rsp_disparity_offset,
   output logic rsp_last_of_pixel,
   output logic rsp_last_of_frame,
   input  logic csr_write,
   input  logic [chsc_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [chsc_pkg::CsrDataWidth-1:0] csr_data
);
   import chsc_pkg::*;

   logic [10:0] width_ff, height_ff;
   logic [5:0] min_disp_ff;
   logic [6:0] disp_count_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 11'd640;
         height_ff <= 11'd480;
         min_disp_ff <= '0;
         disp_count_ff <= 7'd64;
      end else if (csr_write) begin
         unique case (reg_index_type'(csr_index))
            REG_FRAME_WIDTH: width_ff <= csr_data;
            REG_FRAME_HEIGHT: height_ff <= csr_data;
            REG_MIN_DISPARITY: min_disp_ff <= csr_data[5:0];
            REG_DISPARITY_COUNT: disp_count_ff <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   chsc_stream_if #(.payload_type(job_type)) job_ch ();

   chsc_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_kind, .req_left_pixel,
      .req_right_pixel, .cfg_width(width_ff), .cfg_height(height_ff),
      .job_valid(job_ch.valid), .job_ready(job_ch.ready), .job_data(job_ch.data)
   );

   chsc_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_DISP(MAX_DISP)) u_back (
      .clock, .reset, .job_valid(job_ch.valid), .job_ready(job_ch.ready),
      .job_data(job_ch.data), .cfg_min_disp(min_disp_ff),
      .cfg_disp_count(disp_count_ff), .rsp_valid, .rsp_ready, .rsp_match_cost,
      .rsp_disparity_offset, .rsp_last_of_pixel, .rsp_last_of_frame
   );
endmodule
